// ----- rtl/core/nmas_pkg.sv -----
`default_nettype none
package nmas_pkg;

    localparam int MAX_WIDTH_DEF = 1024;
    localparam int PIXEL_BITS    = 8;
    localparam int SUM_BITS      = PIXEL_BITS + 2;
    localparam int ROW_BITS      = 16;
    localparam int COL_BITS      = 10;
    localparam int SHADE_BITS    = 7;
    localparam int FWIDTH_BITS   = 11;
    localparam int FHEIGHT_BITS  = 16;
    localparam int TDATA_BITS    = 48;
    localparam int TUSER_BITS    = 2;
    localparam int APB_ADDR_BITS = 3;
    localparam int APB_DATA_BITS = 32;

    // x / 3 as a multiply by a rounded-up reciprocal, exact for any sum
    localparam int DIV3_SHIFT = SUM_BITS + 1;
    localparam int DIV3_MUL   = ((1 << DIV3_SHIFT) + 2) / 3;
    localparam int PROD_BITS  = SUM_BITS + DIV3_SHIFT;

    localparam logic REG_FRAME_WIDTH  = 1'b0;
    localparam logic REG_FRAME_HEIGHT = 1'b1;

    // which of the results of one input is being sent
    localparam logic [1:0] IDX_ABOVE = 2'd0;
    localparam logic [1:0] IDX_LEFT  = 2'd1;
    localparam logic [1:0] IDX_FINAL = 2'd2;

    localparam logic [SHADE_BITS-1:0] SHADE_NEWLINE = 7'd10;

    function automatic logic [SHADE_BITS-1:0] shade_code(input logic [PIXEL_BITS-1:0] mean);
        logic [SHADE_BITS-1:0] code;
        case (mean)
            8'd0:    code = 7'h20;
            8'd1:    code = 7'h2e;
            8'd2:    code = 7'h2c;
            8'd3:    code = 7'h3a;
            8'd4:    code = 7'h7e;
            8'd5:    code = 7'h2a;
            8'd6:    code = 7'h3d;
            8'd7:    code = 7'h3f;
            8'd8:    code = 7'h25;
            8'd9:    code = 7'h23;
            default: code = SHADE_NEWLINE;
        endcase
        return code;
    endfunction

endpackage
`default_nettype wire

// ----- rtl/core/neighbor_mean_ascii_shade.sv -----
`default_nettype none
// channel   direction  transaction                    payload
// s_*       in         one pixel, raster order        tdata[7:0] pixel
// m_*       out        one filtered pixel             tdata row/col/mean/shade, tuser, tlast
// apb       in         frame_width @0, frame_height @4
//
// one pixel per cycle while s_tready is high; each pixel goes from input to output register
// through the line store read, then sum and divide; the last row gives up to three
// transactions per pixel, one per cycle while m_tready is high, holding s_tready low meanwhile
// rst_n clears counters, store select and valid flags; line stores are not cleared
// a stalled m_tready backs up through one output register and the sum stage
module neighbor_mean_ascii_shade #(
    parameter int MAX_WIDTH = nmas_pkg::MAX_WIDTH_DEF
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                s_tvalid,
    output logic                                     s_tready,
    input  wire logic [7:0]                          s_tdata,  // pixel
    output logic                                     m_tvalid,
    input  wire logic                                m_tready,
    // out_row[15:0], out_col[25:16], mean_value[33:26], shade_char[40:34], zero fill
    output logic [nmas_pkg::TDATA_BITS-1:0]          m_tdata,
    output logic                                     m_tlast,  // last_in_run
    output logic [nmas_pkg::TUSER_BITS-1:0]          m_tuser,  // row_end[0], frame_end[1]
    input  wire logic                                psel,
    input  wire logic                                penable,
    input  wire logic                                pwrite,
    input  wire logic [nmas_pkg::APB_ADDR_BITS-1:0]  paddr,
    input  wire logic [nmas_pkg::APB_DATA_BITS-1:0]  pwdata,
    output logic [nmas_pkg::APB_DATA_BITS-1:0]       prdata,
    output logic                                     pready
);

    localparam int AW = $clog2(MAX_WIDTH);
    localparam int CW = $clog2(MAX_WIDTH + 1);
    localparam int PB = nmas_pkg::PIXEL_BITS;
    localparam int SB = nmas_pkg::SUM_BITS;

    logic [nmas_pkg::FWIDTH_BITS-1:0]  frame_width_reg;
    logic [nmas_pkg::FHEIGHT_BITS-1:0] frame_height_reg;

    logic [AW-1:0]                     col_reg, col_next;
    logic [nmas_pkg::ROW_BITS-1:0]     row_reg, row_next;
    logic                              sel_reg, sel_next;

    logic                              s1_valid_reg, s1_valid_next;
    logic [1:0]                        idx_reg, idx_next;
    logic                              out_valid_reg, out_valid_next;

    logic [PB-1:0] line_store_a [MAX_WIDTH];
    logic [PB-1:0] line_store_b [MAX_WIDTH];
    logic [PB-1:0] rda_reg, rdb_reg;

    logic [PB-1:0]                 s1_pix_reg, q1_reg, q2_reg, pa_reg, pb_reg, first_pix_reg;
    logic                          s1_sel_reg;
    logic [nmas_pkg::ROW_BITS-1:0] s1_row_reg;
    logic [AW-1:0]                 s1_col_reg;
    logic                          s1_top2_reg, s1_left_reg, s1_left2_reg, s1_right_reg;
    logic                          s1_last_col_reg, s1_en2_reg, s1_en3_reg;

    logic [nmas_pkg::ROW_BITS-1:0]   out_row_reg;
    logic [nmas_pkg::COL_BITS-1:0]   out_col_reg;
    logic [PB-1:0]                   out_mean_reg;
    logic [nmas_pkg::SHADE_BITS-1:0] out_shade_reg;
    logic                            out_row_end_reg, out_frame_end_reg, out_last_reg;

    logic [CW-1:0]                     w_eff;
    logic [nmas_pkg::FHEIGHT_BITS-1:0] h_eff;
    logic                              last_col, last_row;
    logic [AW-1:0]                     col_plus, addr_a, addr_b;
    logic                              in_acc, cfg_wr;
    logic [PB-1:0]                     rd_prev, rd_cur;

    logic [nmas_pkg::ROW_BITS-1:0]   res_row;
    logic [AW-1:0]                   res_col;
    logic [SB-1:0]                   res_sum;
    logic [2:0]                      res_cnt;
    logic                            res_row_end, res_frame_end, res_last;
    logic [nmas_pkg::PROD_BITS-1:0]  prod3;
    logic [PB-1:0]                   res_mean;
    logic                            out_load, s1_done;

    // configuration
    assign cfg_wr = psel & penable & pwrite;
    assign pready = 1'b1;

    always_comb
    begin
        if (paddr[2] == nmas_pkg::REG_FRAME_HEIGHT)
        begin
            prdata = nmas_pkg::APB_DATA_BITS'(frame_height_reg);
        end
        else
        begin
            prdata = nmas_pkg::APB_DATA_BITS'(frame_width_reg);
        end
    end

    always_comb
    begin
        if (frame_width_reg < nmas_pkg::FWIDTH_BITS'(2))
        begin
            w_eff = CW'(2);
        end
        else if (32'(frame_width_reg) > 32'(MAX_WIDTH))
        begin
            w_eff = CW'(MAX_WIDTH);
        end
        else
        begin
            w_eff = CW'(frame_width_reg);
        end
        if (frame_height_reg < nmas_pkg::FHEIGHT_BITS'(2))
        begin
            h_eff = nmas_pkg::FHEIGHT_BITS'(2);
        end
        else
        begin
            h_eff = frame_height_reg;
        end
    end

    // input side
    assign in_acc   = s_tvalid & s_tready;
    assign last_col = (CW'(col_reg) + CW'(1)) == w_eff;
    assign last_row = row_reg == (h_eff - nmas_pkg::FHEIGHT_BITS'(1));
    assign col_plus = col_reg + AW'(1);
    // sel_reg high: store a is being rewritten, store b holds the row above
    assign addr_a   = sel_reg ? col_reg : col_plus;
    assign addr_b   = sel_reg ? col_plus : col_reg;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        sel_next = sel_reg;
        if (cfg_wr)
        begin
            col_next = '0;
            row_next = '0;
        end
        else if (in_acc)
        begin
            if (last_col)
            begin
                col_next = '0;
                sel_next = ~sel_reg;
                row_next = last_row ? '0 : row_reg + nmas_pkg::ROW_BITS'(1);
            end
            else
            begin
                col_next = col_plus;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (sel_reg)
            begin
                line_store_a[col_reg] <= s_tdata[PB-1:0];
            end
            rda_reg <= line_store_a[addr_a];
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            if (!sel_reg)
            begin
                line_store_b[col_reg] <= s_tdata[PB-1:0];
            end
            rdb_reg <= line_store_b[addr_b];
        end
    end

    assign rd_prev = s1_sel_reg ? rdb_reg : rda_reg;
    assign rd_cur  = s1_sel_reg ? rda_reg : rdb_reg;

    // neighbor window, kept in step with the stream
    always_ff @(posedge clk)
    begin
        if (in_acc)
        begin
            s1_pix_reg      <= s_tdata[PB-1:0];
            q1_reg          <= s1_pix_reg;
            q2_reg          <= q1_reg;
            pb_reg          <= pa_reg;
            pa_reg          <= (col_reg == '0) ? first_pix_reg : rd_prev;
            if (col_reg == '0)
            begin
                first_pix_reg <= s_tdata[PB-1:0];
            end
            s1_sel_reg      <= sel_reg;
            s1_row_reg      <= row_reg;
            s1_col_reg      <= col_reg;
            s1_top2_reg     <= row_reg >= nmas_pkg::ROW_BITS'(2);
            s1_left_reg     <= col_reg != '0;
            s1_left2_reg    <= col_reg >= AW'(2);
            s1_right_reg    <= !last_col;
            s1_last_col_reg <= last_col;
            s1_en2_reg      <= last_row && (col_reg != '0);
            s1_en3_reg      <= last_row && last_col;
        end
    end

    // result selection
    always_comb
    begin
        res_row       = s1_row_reg - nmas_pkg::ROW_BITS'(1);
        res_col       = s1_col_reg;
        res_sum       = SB'(s1_pix_reg) + (s1_top2_reg ? SB'(rd_cur) : '0)
                      + (s1_left_reg ? SB'(pb_reg) : '0) + (s1_right_reg ? SB'(rd_prev) : '0);
        res_cnt       = 3'd1 + 3'(s1_top2_reg) + 3'(s1_left_reg) + 3'(s1_right_reg);
        res_row_end   = s1_last_col_reg;
        res_frame_end = 1'b0;
        res_last      = !s1_en2_reg;
        case (idx_reg)
            nmas_pkg::IDX_LEFT:
            begin
                res_row       = s1_row_reg;
                res_col       = s1_col_reg - AW'(1);
                res_sum       = SB'(pb_reg) + SB'(s1_pix_reg) + (s1_left2_reg ? SB'(q2_reg) : '0);
                res_cnt       = 3'd2 + 3'(s1_left2_reg);
                res_row_end   = 1'b0;
                res_frame_end = 1'b0;
                res_last      = !s1_en3_reg;
            end
            nmas_pkg::IDX_FINAL:
            begin
                res_row       = s1_row_reg;
                res_col       = s1_col_reg;
                res_sum       = SB'(pa_reg) + SB'(q1_reg);
                res_cnt       = 3'd2;
                res_row_end   = 1'b1;
                res_frame_end = 1'b1;
                res_last      = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    assign prod3 = nmas_pkg::PROD_BITS'(res_sum) * nmas_pkg::PROD_BITS'(nmas_pkg::DIV3_MUL);

    always_comb
    begin
        case (res_cnt)
            3'd3:    res_mean = PB'(prod3[nmas_pkg::PROD_BITS-1:nmas_pkg::DIV3_SHIFT]);
            3'd4:    res_mean = PB'(res_sum >> 2);
            default: res_mean = PB'(res_sum >> 1);
        endcase
    end

    // handshake between the sum stage and the output register
    assign out_load = s1_valid_reg && (!out_valid_reg || m_tready);
    assign s1_done  = out_load && res_last;
    assign s_tready = !s1_valid_reg || s1_done;

    always_comb
    begin
        s1_valid_next = s1_valid_reg;
        idx_next      = idx_reg;
        if (in_acc)
        begin
            s1_valid_next = row_reg != '0;
            idx_next      = nmas_pkg::IDX_ABOVE;
        end
        else if (s1_done)
        begin
            s1_valid_next = 1'b0;
        end
        else if (out_load)
        begin
            case (idx_reg)
                nmas_pkg::IDX_ABOVE: idx_next = nmas_pkg::IDX_LEFT;
                nmas_pkg::IDX_LEFT:  idx_next = nmas_pkg::IDX_FINAL;
                default:             idx_next = nmas_pkg::IDX_FINAL;
            endcase
        end
        if (out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_row_reg       <= res_row;
            out_col_reg       <= nmas_pkg::COL_BITS'(res_col);
            out_mean_reg      <= res_mean;
            out_shade_reg     <= nmas_pkg::shade_code(res_mean);
            out_row_end_reg   <= res_row_end;
            out_frame_end_reg <= res_frame_end;
            out_last_reg      <= res_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= nmas_pkg::FWIDTH_BITS'(2);
            frame_height_reg <= nmas_pkg::FHEIGHT_BITS'(2);
            col_reg          <= '0;
            row_reg          <= '0;
            sel_reg          <= 1'b0;
            s1_valid_reg     <= 1'b0;
            idx_reg          <= nmas_pkg::IDX_ABOVE;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            if (cfg_wr)
            begin
                if (paddr[2] == nmas_pkg::REG_FRAME_HEIGHT)
                begin
                    frame_height_reg <= pwdata[nmas_pkg::FHEIGHT_BITS-1:0];
                end
                else
                begin
                    frame_width_reg <= pwdata[nmas_pkg::FWIDTH_BITS-1:0];
                end
            end
            col_reg       <= col_next;
            row_reg       <= row_next;
            sel_reg       <= sel_next;
            s1_valid_reg  <= s1_valid_next;
            idx_reg       <= idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {7'd0, out_shade_reg, out_mean_reg, out_col_reg, out_row_reg};
    assign m_tuser  = {out_frame_end_reg, out_row_end_reg};
    assign m_tlast  = out_last_reg;

endmodule
`default_nettype wire

// ----- dv/neighbor_mean_ascii_shade_checker.sv -----
module neighbor_mean_ascii_shade_checker
    import nmas_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     s_tvalid,
    input  logic                     s_tready,
    input  logic [7:0]               s_tdata,   // pixel
    input  logic                     m_tvalid,
    input  logic                     m_tready,
    // out_row[15:0], out_col[25:16], mean_value[33:26], shade_char[40:34], zero fill
    input  logic [TDATA_BITS-1:0]    m_tdata,
    input  logic                     m_tlast,   // last_in_run
    input  logic [TUSER_BITS-1:0]    m_tuser,   // row_end[0], frame_end[1]
    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [APB_ADDR_BITS-1:0] paddr,
    input  logic [APB_DATA_BITS-1:0] pwdata,
    input  logic                     pready,
    output int                       fail_total,
    output int                       results_owed
);

    typedef struct packed {
        logic [ROW_BITS-1:0]   out_row;
        logic [COL_BITS-1:0]   out_col;
        logic [PIXEL_BITS-1:0] mean_value;
        logic [SHADE_BITS-1:0] shade_char;
        logic                  row_end;
        logic                  frame_end;
        logic                  last_in_run;
    } shaded_pixel_t;

    // darkest first, one character per mean value 0..9
    localparam logic [79:0] SHADE_RAMP = " .,:~*=?%#";

    shaded_pixel_t   due_pixels [$];
    logic [7:0]      row_mem [0:1][0:MAX_WIDTH_DEF-1];
    int              width_reg;
    int              height_reg;
    int              row_at;
    int              col_at;
    int              newest;
    int              mismatch_count;

    function automatic shaded_pixel_t shade_pixel(input int r, input int c, input int sum,
                                                  input int cnt, input int w, input int h);
        shaded_pixel_t px;
        int            mean;
        mean           = sum / cnt;
        px.out_row     = r[ROW_BITS-1:0];
        px.out_col     = c[COL_BITS-1:0];
        px.mean_value  = mean[PIXEL_BITS-1:0];
        px.shade_char  = (mean < 10) ? SHADE_RAMP[78 - 8 * mean -: 7] : SHADE_NEWLINE;
        px.row_end     = (c == w - 1);
        px.frame_end   = (r == h - 1) && (c == w - 1);
        px.last_in_run = 1'b0;
        return px;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : track
        shaded_pixel_t made [3];
        shaded_pixel_t want;
        shaded_pixel_t seen;
        int            w;
        int            h;
        int            r;
        int            c;
        int            sum;
        int            cnt;
        int            older;
        int            fresh;
        int            n;
        int            p;
        if (!rst_n)
        begin
            due_pixels.delete();
            for (int i = 0; i < MAX_WIDTH_DEF; i++)
            begin
                row_mem[0][i] = '0;
                row_mem[1][i] = '0;
            end
            width_reg      = 2;
            height_reg     = 2;
            row_at         = 0;
            col_at         = 0;
            newest         = 0;
            mismatch_count = 0;
            fail_total     <= 0;
            results_owed   <= 0;
        end
        else
        begin
            // output transaction against the oldest prediction
            if (m_tvalid && m_tready)
            begin
                seen.out_row     = m_tdata[15:0];
                seen.out_col     = m_tdata[25:16];
                seen.mean_value  = m_tdata[33:26];
                seen.shade_char  = m_tdata[40:34];
                seen.row_end     = m_tuser[0];
                seen.frame_end   = m_tuser[1];
                seen.last_in_run = m_tlast;
                if (due_pixels.size() == 0)
                begin
                    $error("unexpected transaction: out_row %0d, out_col %0d",
                           seen.out_row, seen.out_col);
                    mismatch_count++;
                end
                else
                begin
                    want = due_pixels.pop_front();
                    if (seen.out_row !== want.out_row)
                    begin
                        $error("out_row: expected %0d, got %0d", want.out_row, seen.out_row);
                        mismatch_count++;
                    end
                    if (seen.out_col !== want.out_col)
                    begin
                        $error("out_col: expected %0d, got %0d", want.out_col, seen.out_col);
                        mismatch_count++;
                    end
                    if (seen.mean_value !== want.mean_value)
                    begin
                        $error("mean_value: expected %0d, got %0d",
                               want.mean_value, seen.mean_value);
                        mismatch_count++;
                    end
                    if (seen.shade_char !== want.shade_char)
                    begin
                        $error("shade_char: expected %0d, got %0d",
                               want.shade_char, seen.shade_char);
                        mismatch_count++;
                    end
                    if (seen.row_end !== want.row_end)
                    begin
                        $error("row_end: expected %0d, got %0d", want.row_end, seen.row_end);
                        mismatch_count++;
                    end
                    if (seen.frame_end !== want.frame_end)
                    begin
                        $error("frame_end: expected %0d, got %0d",
                               want.frame_end, seen.frame_end);
                        mismatch_count++;
                    end
                    if (seen.last_in_run !== want.last_in_run)
                    begin
                        $error("last_in_run: expected %0d, got %0d",
                               want.last_in_run, seen.last_in_run);
                        mismatch_count++;
                    end
                end
            end

            // input transaction: filtered pixels it releases
            if (s_tvalid && s_tready)
            begin
                w = width_reg;
                if (w < 2)
                    w = 2;
                if (w > MAX_WIDTH_DEF)
                    w = MAX_WIDTH_DEF;
                h = height_reg;
                if (h < 2)
                    h = 2;
                if (col_at >= w)
                    col_at = 0;
                if (row_at >= h)
                    row_at = 0;
                r     = row_at;
                c     = col_at;
                p     = s_tdata;
                older = newest;
                fresh = newest ^ 1;
                n     = 0;

                // pixel above, now that its lower neighbor is here
                if (r >= 1)
                begin
                    sum = p;
                    cnt = 1;
                    if (r >= 2)
                    begin
                        sum += row_mem[fresh][c];
                        cnt++;
                    end
                    if (c >= 1)
                    begin
                        sum += row_mem[older][c - 1];
                        cnt++;
                    end
                    if (c + 1 < w)
                    begin
                        sum += row_mem[older][c + 1];
                        cnt++;
                    end
                    made[n] = shade_pixel(r - 1, c, sum, cnt, w, h);
                    n++;
                end

                row_mem[fresh][c] = p[7:0];

                // bottom row finishes while it streams in
                if (r == h - 1 && c >= 1)
                begin
                    sum = row_mem[older][c - 1] + p;
                    cnt = 2;
                    if (c >= 2)
                    begin
                        sum += row_mem[fresh][c - 2];
                        cnt++;
                    end
                    made[n] = shade_pixel(r, c - 1, sum, cnt, w, h);
                    n++;
                end
                if (r == h - 1 && c == w - 1)
                begin
                    sum     = row_mem[older][c] + row_mem[fresh][c - 1];
                    made[n] = shade_pixel(r, c, sum, 2, w, h);
                    n++;
                end

                for (int k = 0; k < n; k++)
                begin
                    made[k].last_in_run = (k == n - 1);
                    due_pixels.push_back(made[k]);
                end

                c++;
                if (c >= w)
                begin
                    c      = 0;
                    newest = newest ^ 1;
                    r++;
                    if (r >= h)
                        r = 0;
                end
                col_at = c;
                row_at = r;
            end

            // register write restarts the frame
            if (psel && penable && pwrite && pready)
            begin
                if (paddr == {REG_FRAME_WIDTH, 2'b00})
                begin
                    width_reg = pwdata[FWIDTH_BITS-1:0];
                    row_at    = 0;
                    col_at    = 0;
                end
                else if (paddr == {REG_FRAME_HEIGHT, 2'b00})
                begin
                    height_reg = pwdata[FHEIGHT_BITS-1:0];
                    row_at     = 0;
                    col_at     = 0;
                end
            end

            fail_total   <= mismatch_count;
            results_owed <= due_pixels.size();
        end
    end

endmodule

// ----- dv/neighbor_mean_ascii_shade_test.sv -----
module neighbor_mean_ascii_shade_test;
    import nmas_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOLD_CYCLES = 200;
    localparam int SETTLE      = 10;

    logic                     clk;
    logic                     rst_n;
    logic                     s_tvalid;
    logic                     s_tready;
    logic [7:0]               s_tdata;
    logic                     m_tvalid;
    logic                     m_tready;
    logic [TDATA_BITS-1:0]    m_tdata;
    logic                     m_tlast;
    logic [TUSER_BITS-1:0]    m_tuser;
    logic                     psel;
    logic                     penable;
    logic                     pwrite;
    logic [APB_ADDR_BITS-1:0] paddr;
    logic [APB_DATA_BITS-1:0] pwdata;
    logic [APB_DATA_BITS-1:0] prdata;
    logic                     pready;
    int                       fail_total;
    int                       results_owed;

    int                       tx_idle_pct = 20;
    int                       rx_idle_pct = 83;
    int                       hold_asks   = 0;

    neighbor_mean_ascii_shade dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    neighbor_mean_ascii_shade_checker shade_watch (
        .clk          (clk),
        .rst_n        (rst_n),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tlast      (m_tlast),
        .m_tuser      (m_tuser),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .pready       (pready),
        .fail_total   (fail_total),
        .results_owed (results_owed)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        repeat (CYCLE_LIMIT) @(posedge clk);
        $display("neighbor_mean_ascii_shade_test NOT OK");
        $finish;
    end

    // output side: random stalls plus one long hold-off on request
    initial
    begin
        int hold_seen;
        int hold_left;
        hold_seen = 0;
        hold_left = 0;
        m_tready  = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_seen != hold_asks)
            begin
                hold_seen = hold_asks;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                m_tready <= 1'b0;
            end
            else
                m_tready <= ($urandom_range(0, 99) >= rx_idle_pct);
        end
    end

    function automatic logic [7:0] pick_pixel(input bit dim);
        logic [7:0] v;
        if (dim || $urandom_range(0, 3) == 0)
            v = 8'($urandom_range(0, 13));
        else
            v = 8'($urandom_range(0, 255));
        return v;
    endfunction

    task automatic send_pixel(input logic [7:0] pix);
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= pix;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    // hold the input until every predicted transaction has come out
    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (results_owed != 0) @(posedge clk);
    endtask

    task automatic reg_write(input logic [APB_ADDR_BITS-1:0] addr,
                             input logic [APB_DATA_BITS-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready) @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic configure(input int w, input int h);
        drain();
        repeat (SETTLE) @(posedge clk);
        reg_write({REG_FRAME_WIDTH, 2'b00}, ($urandom & ~32'h7ff) | w[FWIDTH_BITS-1:0]);
        reg_write({REG_FRAME_HEIGHT, 2'b00}, ($urandom & ~32'hffff) | h[FHEIGHT_BITS-1:0]);
    endtask

    initial
    begin
        int random_items;
        int w;
        int h;
        int ew;
        int eh;
        int count;
        bit dim;
        bit pressed;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        psel         = 1'b0;
        penable      = 1'b0;
        pwrite       = 1'b0;
        paddr        = '0;
        pwdata       = '0;
        rst_n        = 1'b0;
        random_items = 0;
        pressed      = 1'b0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset size 2x2, all corners
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);

        // 3x3 gives corners, edges and one inside pixel
        configure(3, 3);
        send_pixel(8'd9);
        send_pixel(8'd0);
        send_pixel(8'd255);
        send_pixel(8'd3);
        send_pixel(8'd7);
        send_pixel(8'd12);
        send_pixel(8'd1);
        send_pixel(8'd200);
        send_pixel(8'd5);

        // sizes below the minimum act as 2
        configure(0, 1);
        send_pixel(8'd255);
        send_pixel(8'd255);
        send_pixel(8'd0);
        send_pixel(8'd255);
        configure(1, 0);
        send_pixel(8'd3);
        send_pixel(8'd8);
        send_pixel(8'd1);
        send_pixel(8'd0);

        while (random_items < 440)
        begin
            if (random_items < 160)
            begin
                tx_idle_pct = 20;
                rx_idle_pct = 83;
            end
            else if (random_items < 320)
            begin
                tx_idle_pct = 83;
                rx_idle_pct = 20;
            end
            else
            begin
                tx_idle_pct = 0;
                rx_idle_pct = 0;
            end

            if (!pressed && random_items >= 320)
            begin
                // long output stall with the input still offered, then a full pause
                pressed = 1'b1;
                configure(4, 5);
                hold_asks++;
                repeat (20) send_pixel(pick_pixel(1'b0));
                drain();
                repeat (20) send_pixel(pick_pixel(1'b0));
                random_items += 40;
            end

            case ($urandom_range(0, 9))
                0:       w = $urandom_range(0, 1);
                1:       w = $urandom_range(9, 40);
                default: w = $urandom_range(2, 8);
            endcase
            case ($urandom_range(0, 9))
                0:       h = $urandom_range(0, 1);
                1:       h = 65535;
                2:       h = $urandom_range(7, 65535);
                default: h = $urandom_range(2, 6);
            endcase
            ew = (w < 2) ? 2 : w;
            eh = (h < 2) ? 2 : h;
            if (ew * eh <= 60 && $urandom_range(0, 9) < 7)
                count = ew * eh * $urandom_range(1, 2);
            else
                count = $urandom_range(1, 3 * ew + 2);
            dim = ($urandom_range(0, 3) == 0);

            configure(w, h);
            repeat (count) send_pixel(pick_pixel(dim));
            random_items += count;
        end

        drain();
        repeat (SETTLE) @(posedge clk);
        if (fail_total == 0 && results_owed == 0)
            $display("neighbor_mean_ascii_shade_test OK");
        else
            $display("neighbor_mean_ascii_shade_test NOT OK");
        $finish;
    end

endmodule

// ----- sim.f -----
rtl/core/nmas_pkg.sv
rtl/core/neighbor_mean_ascii_shade.sv
dv/neighbor_mean_ascii_shade_checker.sv
dv/neighbor_mean_ascii_shade_test.sv
